// ----- src/ked_pkg.sv -----
`default_nettype none

package ked_pkg;

	// one input transaction: received byte or millisecond tick
	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
	} ked_in_t;

	// one decoded key event
	typedef struct packed {
		logic [3:0] key;
		logic [3:0] digit;
	} ked_out_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [3:0] KC_UP      = 4'd0;
	localparam logic [3:0] KC_DOWN    = 4'd1;
	localparam logic [3:0] KC_LEFT    = 4'd2;
	localparam logic [3:0] KC_RIGHT   = 4'd3;
	localparam logic [3:0] KC_ENTER   = 4'd4;
	localparam logic [3:0] KC_ESCAPE  = 4'd5;
	localparam logic [3:0] KC_REFRESH = 4'd6;
	localparam logic [3:0] KC_MUTE    = 4'd7;
	localparam logic [3:0] KC_FREQ    = 4'd8;
	localparam logic [3:0] KC_OPTIONS = 4'd9;
	localparam logic [3:0] KC_STEREO  = 4'd10;
	localparam logic [3:0] KC_DIGIT   = 4'd11;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_CSI  = 2'd2;

	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_SS3     = 8'h4F;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_UC_B    = 8'h42;
	localparam logic [7:0] CH_UC_C    = 8'h43;
	localparam logic [7:0] CH_UC_D    = 8'h44;
	localparam logic [7:0] CH_UC_Z    = 8'h5A;
	localparam logic [7:0] CH_LC_H    = 8'h68;
	localparam logic [7:0] CH_LC_J    = 8'h6A;
	localparam logic [7:0] CH_LC_K    = 8'h6B;
	localparam logic [7:0] CH_LC_L    = 8'h6C;
	localparam logic [7:0] CH_LC_M    = 8'h6D;
	localparam logic [7:0] CH_LC_O    = 8'h6F;
	localparam logic [7:0] CH_LC_P    = 8'h70;
	localparam logic [7:0] CH_LC_R    = 8'h72;
	localparam logic [7:0] CH_LC_S    = 8'h73;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam logic [15:0] TIMEOUT_RESET = 16'd60;

endpackage

`default_nettype wire

// ----- src/ked_parser.sv -----
`default_nettype none

module ked_parser import ked_pkg::*; #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire ked_in_t     item,
	input  wire logic [15:0] timeout,
	output logic             hit,
	output ked_out_t         result
);

	localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

	logic [1:0]                 phase_q;
	logic [1:0]                 phase_d;
	logic [TICK_COUNT_BITS-1:0] ticks_q;
	logic [TICK_COUNT_BITS-1:0] ticks_inc;
	logic [TICK_COUNT_BITS-1:0] ticks_d;
	logic [15:0]                limit;
	logic [7:0]                 c;
	logic [7:0]                 lc;
	logic                       idle_hit;
	logic [3:0]                 idle_key;
	logic [3:0]                 idle_digit;

	assign c  = item.byte_value;
	assign lc = (c >= CH_UC_A && c <= CH_UC_Z) ? (c | CASE_BIT) : c;

	// single-byte key map in idle phase
	always_comb begin
		idle_hit   = 1'b1;
		idle_key   = KC_UP;
		idle_digit = 4'd0;
		case (lc)
			CH_CR:    idle_key = KC_ENTER;
			CH_LC_K:  idle_key = KC_UP;
			CH_LC_J:  idle_key = KC_DOWN;
			CH_LC_H:  idle_key = KC_LEFT;
			CH_MINUS: idle_key = KC_LEFT;
			CH_LC_L:  idle_key = KC_RIGHT;
			CH_PLUS:  idle_key = KC_RIGHT;
			CH_LC_R:  idle_key = KC_REFRESH;
			CH_LC_M:  idle_key = KC_MUTE;
			CH_LC_P:  idle_key = KC_FREQ;
			CH_LC_O:  idle_key = KC_OPTIONS;
			CH_LC_S:  idle_key = KC_STEREO;
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					idle_key   = KC_DIGIT;
					idle_digit = c[3:0];
				end else begin
					idle_hit = 1'b0;
				end
			end
		endcase
	end

	assign limit     = (timeout == 16'd0) ? 16'd1 : timeout;
	assign ticks_inc = (&ticks_q) ? ticks_q : ticks_q + 1'b1;

	always_comb begin
		phase_d      = phase_q;
		ticks_d      = ticks_q;
		hit          = 1'b0;
		result.key   = KC_ESCAPE;
		result.digit = 4'd0;
		if (item.command == CMD_TICK) begin
			ticks_d = ticks_inc;
			if (phase_q == PH_ESC && CW'(ticks_inc) >= CW'(limit)) begin
				phase_d = PH_IDLE;
				hit     = 1'b1;
			end
		end else begin
			ticks_d = '0;
			case (phase_q)
				PH_IDLE: begin
					if (c == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						hit          = idle_hit;
						result.key   = idle_key;
						result.digit = idle_digit;
					end
				end
				PH_ESC: begin
					if (c == CH_BRACKET || c == CH_SS3) begin
						phase_d = PH_CSI;
					end else begin
						phase_d = PH_IDLE;
						hit     = 1'b1;
					end
				end
				default: begin
					// arrow final byte; unreachable code 3 acts the same
					phase_d = PH_IDLE;
					hit     = 1'b1;
					case (c)
						CH_UC_A: result.key = KC_UP;
						CH_UC_B: result.key = KC_DOWN;
						CH_UC_C: result.key = KC_RIGHT;
						CH_UC_D: result.key = KC_LEFT;
						default: hit = 1'b0;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
		end
	end

`ifndef SYNTHESIS
	a_byte_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command == CMD_BYTE |=> ticks_q == '0)
		else $error("tick count not cleared by byte");

	a_csi_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_CSI |=> phase_q == PH_IDLE)
		else $error("parser stuck after arrow prefix");

	a_tick_no_key_outside_esc: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command == CMD_TICK && phase_q != PH_ESC |-> !hit)
		else $error("tick produced key outside escape phase");
`endif

endmodule

`default_nettype wire

// ----- src/ked_out_reg.sv -----
`default_nettype none

module ked_out_reg import ked_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire logic     hit,
	input  wire ked_out_t result,
	input  wire logic     stall,
	output logic          valid,
	output ked_out_t      data
);

	logic     valid_q;
	ked_out_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= hit;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && hit) begin
			data_q <= result;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

`default_nettype wire

// ----- src/terminal_key_escape_decoder_top.sv -----
// Terminal key decoder: turns received terminal bytes and millisecond ticks
// into key events (arrows, enter, escape, letter keys, digits).
// Request channel: req_valid / req_stall / req. Each transaction carries a
//   command bit (byte or tick) and the byte value. Taken when req_valid is
//   high and req_stall is low.
// Event channel: evt_valid / evt_stall / evt with key code and digit value.
//   Bytes or ticks that decode to nothing produce no event.
// Config channel: cfg_valid / cfg_ready / cfg_data writes the escape timeout
//   in ticks; cfg_ready is always high. Write only while the block is idle.
// Throughput: one transaction per cycle while evt_stall does not hold a pending
//   event, set by the single decode stage between the request register and the event register.
// Path: a taken request goes into the request register, is decoded, and its
//   event is loaded into the event register, which drives evt_valid.
// When evt_stall holds a pending event, the request register fills and
//   req_stall rises in the same cycle; nothing is dropped.
// Reset (arst_n low, asynchronous): parser idle, tick count zero, timeout
//   back to 60 ticks, both pipeline registers empty.
`default_nettype none

module terminal_key_escape_decoder_top import ked_pkg::*; #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire ked_in_t     req,
	output logic             evt_valid,
	input  wire logic        evt_stall,
	output ked_out_t         evt,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic        req_valid_s1;
	ked_in_t     req_s1;
	logic        advance;
	logic        accept;
	logic        hit;
	ked_out_t    result;
	logic [15:0] timeout_q;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// stage 1 moves on whenever the event register is free or draining
	assign advance   = req_valid_s1 && (!evt_valid || !evt_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	ked_parser #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (req_s1),
		.timeout (timeout_q),
		.hit     (hit),
		.result  (result)
	);

	ked_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.hit    (hit),
		.result (result),
		.stall  (evt_stall),
		.valid  (evt_valid),
		.data   (evt)
	);

endmodule

`default_nettype wire

// ----- verif/terminal_key_escape_decoder_top_test.sv -----
module terminal_key_escape_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ked_pkg::*;

	// Checks the key decoder against a predictor that is kept in step with
	// every transaction the block accepts. A short table covers the key map
	// and the escape sequences. Random escape sequences, lone escapes with
	// tick runs, and noise then run under several timeout settings, with
	// random gaps and stalls on both channels.

	localparam int TICK_BITS     = 16;
	localparam int SETTLE_CYCLES = 4;  // time for the pipeline to empty, plus margin

	// directed table: expectation typed in by hand, or left to the predictor
	localparam logic ROW_TYPED   = 1'b1;
	localparam logic ROW_MODELED = 1'b0;
	localparam logic EVT_YES     = 1'b1;
	localparam logic EVT_NONE    = 1'b0;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
		logic       typed;
		logic       has_evt;
		logic [3:0] key;
		logic [3:0] digit;
	} probe_t;

	localparam int PROBE_ROWS = 27;
	localparam probe_t PROBES [PROBE_ROWS] = '{
		'{CMD_TICK, 8'hFF,               ROW_TYPED,   EVT_NONE, 4'd0,      4'd0}, // idle tick
		'{CMD_BYTE, 8'h00,               ROW_TYPED,   EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_CR,               ROW_TYPED,   EVT_YES,  KC_ENTER,  4'd0},
		'{CMD_BYTE, CH_LC_K,             ROW_TYPED,   EVT_YES,  KC_UP,     4'd0},
		'{CMD_BYTE, CH_LC_J ^ CASE_BIT,  ROW_TYPED,   EVT_YES,  KC_DOWN,   4'd0},
		'{CMD_BYTE, CH_LC_H,             ROW_TYPED,   EVT_YES,  KC_LEFT,   4'd0},
		'{CMD_BYTE, CH_MINUS,            ROW_TYPED,   EVT_YES,  KC_LEFT,   4'd0},
		'{CMD_BYTE, CH_LC_L ^ CASE_BIT,  ROW_TYPED,   EVT_YES,  KC_RIGHT,  4'd0},
		'{CMD_BYTE, CH_PLUS,             ROW_TYPED,   EVT_YES,  KC_RIGHT,  4'd0},
		'{CMD_BYTE, CH_LC_R ^ CASE_BIT,  ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_LC_M,             ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_LC_P ^ CASE_BIT,  ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_SS3,              ROW_TYPED,   EVT_YES,  KC_OPTIONS, 4'd0}, // idle 'O'
		'{CMD_BYTE, CH_LC_S,             ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_ZERO,             ROW_TYPED,   EVT_YES,  KC_DIGIT,  4'd0},
		'{CMD_BYTE, CH_NINE,             ROW_TYPED,   EVT_YES,  KC_DIGIT,  4'd9},
		'{CMD_BYTE, CH_ESC,              ROW_TYPED,   EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_BRACKET,          ROW_TYPED,   EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_UC_A,             ROW_TYPED,   EVT_YES,  KC_UP,     4'd0},
		'{CMD_BYTE, CH_ESC,              ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_SS3,              ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_UC_D,             ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_ESC,              ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_ESC,              ROW_TYPED,   EVT_YES,  KC_ESCAPE, 4'd0}, // ESC ESC
		'{CMD_BYTE, CH_ESC,              ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_BRACKET,          ROW_MODELED, EVT_NONE, 4'd0,      4'd0},
		'{CMD_BYTE, CH_UC_Z,             ROW_MODELED, EVT_NONE, 4'd0,      4'd0}  // bad final
	};

	// lower-case letter keys; upper case is made by flipping the case bit
	localparam logic [7:0] KEY_LETTERS [9] = '{
		CH_LC_K, CH_LC_J, CH_LC_H, CH_LC_L, CH_LC_R, CH_LC_M, CH_LC_P, CH_LC_O, CH_LC_S
	};

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	ked_in_t  req;
	logic     evt_valid;
	logic     evt_stall;
	ked_out_t evt;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [15:0] cfg_data;

	terminal_key_escape_decoder_top #(
		.TICK_COUNT_BITS(TICK_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predictor state, mirrors the parser inside the block
	logic [1:0]           parse_phase;
	logic [TICK_BITS-1:0] tick_count;
	logic [15:0]          esc_timeout;

	ked_out_t pending_keys[$];   // decoded keys still owed by the block

	int  error_count     = 0;
	int  items_sent      = 0;
	int  events_checked  = 0;
	int  timeout_escapes = 0;
	int  settings_used   = 1;    // the reset value counts as one
	bit  req_calm        = 1'b0; // stretch of back-to-back transactions
	bit  evt_calm        = 1'b0; // stretch with no event stalls

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		error_count++;
	endtask

	// idle-phase single byte map; returns 1 when the byte is a key
	function automatic bit idle_key(input logic [7:0] ch, output ked_out_t ev);
		logic [7:0] lc;
		ev = '0;
		lc = (ch >= CH_UC_A && ch <= CH_UC_Z) ? (ch | CASE_BIT) : ch;
		idle_key = 1'b1;
		if (ch == CH_CR) ev.key = KC_ENTER;
		else if (lc == CH_LC_K) ev.key = KC_UP;
		else if (lc == CH_LC_J) ev.key = KC_DOWN;
		else if (lc == CH_LC_H || ch == CH_MINUS) ev.key = KC_LEFT;
		else if (lc == CH_LC_L || ch == CH_PLUS) ev.key = KC_RIGHT;
		else if (lc == CH_LC_R) ev.key = KC_REFRESH;
		else if (lc == CH_LC_M) ev.key = KC_MUTE;
		else if (lc == CH_LC_P) ev.key = KC_FREQ;
		else if (lc == CH_LC_O) ev.key = KC_OPTIONS;
		else if (lc == CH_LC_S) ev.key = KC_STEREO;
		else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			ev.key   = KC_DIGIT;
			ev.digit = ch[3:0];  // ASCII digits sit at 0x30..0x39
		end else idle_key = 1'b0;
	endfunction

	// advance the predictor by one accepted transaction
	function automatic bit predict_key(input ked_in_t item, output ked_out_t ev);
		logic [15:0] limit;
		bit          hit;
		ev  = '0;
		hit = 1'b0;
		if (item.command == CMD_TICK) begin
			limit = (esc_timeout == 16'd0) ? 16'd1 : esc_timeout;
			if (tick_count != '1) tick_count++;
			if (parse_phase == PH_ESC && tick_count >= limit) begin
				parse_phase = PH_IDLE;
				ev.key      = KC_ESCAPE;
				hit         = 1'b1;
			end
		end else begin
			tick_count = '0;
			case (parse_phase)
				PH_IDLE: begin
					if (item.byte_value == CH_ESC) parse_phase = PH_ESC;
					else hit = idle_key(item.byte_value, ev);
				end
				PH_ESC: begin
					if (item.byte_value == CH_BRACKET || item.byte_value == CH_SS3) begin
						parse_phase = PH_CSI;
					end else begin
						// the byte after ESC is swallowed
						parse_phase = PH_IDLE;
						ev.key      = KC_ESCAPE;
						hit         = 1'b1;
					end
				end
				default: begin
					parse_phase = PH_IDLE;
					hit         = 1'b1;
					case (item.byte_value)
						CH_UC_A: ev.key = KC_UP;
						CH_UC_B: ev.key = KC_DOWN;
						CH_UC_C: ev.key = KC_RIGHT;
						CH_UC_D: ev.key = KC_LEFT;
						default: hit = 1'b0;
					endcase
				end
			endcase
		end
		return hit;
	endfunction

	// one request transaction; the prediction is made once it is accepted
	task automatic push_request(input ked_in_t item, input logic typed,
			input logic typed_has, input ked_out_t typed_evt);
		int       gap;
		ked_out_t ev;
		bit       hit;
		if ($urandom_range(0, 24) == 0) req_calm = !req_calm;
		gap = req_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		hit = predict_key(item, ev);
		if (typed) begin
			hit = typed_has;
			ev  = typed_evt;
		end
		if (hit) begin
			pending_keys.push_back(ev);
			if (item.command == CMD_TICK) timeout_escapes++;
		end
		items_sent++;
	endtask

	task automatic send(input logic cmd, input logic [7:0] ch);
		ked_in_t item;
		item.command    = cmd;
		item.byte_value = ch;
		push_request(item, ROW_MODELED, EVT_NONE, '0);
	endtask

	// all requests in, all events out, then let the pipeline empty
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_keys.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		esc_timeout  = value;
		settings_used++;
	endtask

	// one random sequence: mostly well-formed escapes and keys, some noise
	task automatic play_sequence();
		int         kind;
		int         n;
		int         lim;
		logic [7:0] ch;
		kind = $urandom_range(0, 99);
		lim  = (esc_timeout == 16'd0) ? 1 : esc_timeout;
		if (kind < 25) begin
			// arrow: ESC, '[' or 'O', then mostly A..D
			send(CMD_BYTE, CH_ESC);
			send(CMD_BYTE, $urandom_range(0, 1) ? CH_BRACKET : CH_SS3);
			if ($urandom_range(0, 4) != 0) send(CMD_BYTE, CH_UC_A + 8'($urandom_range(0, 3)));
			else send(CMD_BYTE, 8'($urandom));
		end else if (kind < 45) begin
			// lone ESC, then a tick run around the timeout (a short run above 64)
			send(CMD_BYTE, CH_ESC);
			if (lim > 64) n = $urandom_range(0, 8);
			else if ($urandom_range(0, 1)) n = lim - 1 + $urandom_range(0, 2);
			else n = $urandom_range(0, lim + 2);
			repeat (n) send(CMD_TICK, 8'($urandom));
			if ($urandom_range(0, 1)) send(CMD_BYTE, 8'($urandom));
		end else if (kind < 55) begin
			send(CMD_BYTE, CH_ESC);
			send(CMD_BYTE, 8'($urandom));
		end else if (kind < 80) begin
			n = $urandom_range(0, 13);
			case (n)
				9:  ch = CH_CR;
				10: ch = CH_PLUS;
				11: ch = CH_MINUS;
				12, 13: ch = CH_ZERO + 8'($urandom_range(0, 9));
				default: begin
					ch = KEY_LETTERS[n];
					if ($urandom_range(0, 1)) ch = ch ^ CASE_BIT;
				end
			endcase
			send(CMD_BYTE, ch);
		end else if (kind < 90) begin
			send(CMD_BYTE, 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 5)) send(CMD_TICK, 8'($urandom));
		end
	endtask

	task automatic random_phase(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count) play_sequence();
	endtask

	// event side: random stall per transaction, checks in arrival order
	initial begin : event_sink
		int       hold;
		ked_out_t want;
		forever begin
			if ($urandom_range(0, 24) == 0) evt_calm = !evt_calm;
			hold = evt_calm ? 0 : $urandom_range(0, 18);
			if (hold > 0) begin
				evt_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			evt_stall <= 1'b0;
			do @(posedge clk); while (!evt_valid);
			if (pending_keys.size() == 0) begin
				report_mismatch($sformatf("key %0d digit %0d arrived with none owed",
					evt.key, evt.digit));
			end else begin
				want = pending_keys.pop_front();
				if (evt.key !== want.key)
					report_mismatch($sformatf("key %0d, wanted %0d", evt.key, want.key));
				if (evt.digit !== want.digit)
					report_mismatch($sformatf("digit %0d, wanted %0d", evt.digit, want.digit));
				events_checked++;
			end
		end
	end

	// main stimulus
	initial begin : stimulus
		ked_in_t  probe_in;
		ked_out_t probe_evt;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		parse_phase  = PH_IDLE;
		tick_count   = '0;
		esc_timeout  = TIMEOUT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, timeout still at its reset value
		for (int r = 0; r < PROBE_ROWS; r++) begin
			probe_in.command    = PROBES[r].command;
			probe_in.byte_value = PROBES[r].byte_value;
			probe_evt.key       = PROBES[r].key;
			probe_evt.digit     = PROBES[r].digit;
			push_request(probe_in, PROBES[r].typed, PROBES[r].has_evt, probe_evt);
		end
		random_phase(110);

		// shortest timeout: one tick after a lone ESC
		wait_idle();
		write_timeout(16'd1);
		random_phase(90);

		// zero behaves as one
		wait_idle();
		write_timeout(16'd0);
		random_phase(60);

		// longest timeout: short tick runs after a lone ESC never reach it
		wait_idle();
		write_timeout(16'hFFFF);
		random_phase(40);

		// a small random timeout for the bulk of the run
		wait_idle();
		write_timeout(16'($urandom_range(2, 12)));
		random_phase(130);

		wait_idle();
		$display("covered %0d request transactions and %0d key events, %0d of them",
			items_sent, events_checked, timeout_escapes);
		$display("escapes from a tick timeout, across %0d timeout settings", settings_used);
		if (error_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("run stopped by watchdog, %0d keys still owed", pending_keys.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
